### src/aarm_pkg.sv
// shared types, widths and constants of the axis-angle rotation matrix block
// fixed-point formats are Q30 internally; no dependencies
package aarm_pkg;

   localparam int FRAC_BITS_DEF = 14;

   localparam int CW           = 36;  // angle, cordic x/y/z
   localparam int UW           = 32;  // unit axis component
   localparam int PW           = 34;  // product operands
   localparam int CORDIC_STEPS = 30;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 31;

   localparam logic signed [CW-1:0] Q30_ONE     = 36'sd1073741824;
   localparam logic signed [CW-1:0] Q30_PI      = 36'sd3373259426;
   localparam logic signed [CW-1:0] Q30_TWO_PI  = 36'sd6746518852;
   localparam logic signed [CW-1:0] Q30_HALF_PI = 36'sd1686629713;
   localparam logic signed [CW-1:0] CORDIC_X0   = 36'sd652032874;

   typedef struct packed {
      logic signed [15:0] angle;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] col0_x;
      logic signed [15:0] col0_y;
      logic signed [15:0] col0_z;
      logic signed [15:0] col1_x;
      logic signed [15:0] col1_y;
      logic signed [15:0] col1_z;
      logic signed [15:0] col2_x;
      logic signed [15:0] col2_y;
      logic signed [15:0] col2_z;
      logic               bad_axis;
   } rsp_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic signed [CW-1:0] atan_q30(input int i);
      case (i)
         0:       return 36'sd843314856;
         1:       return 36'sd497837829;
         2:       return 36'sd263043836;
         3:       return 36'sd133525158;
         4:       return 36'sd67021686;
         5:       return 36'sd33543515;
         6:       return 36'sd16775850;
         7:       return 36'sd8388437;
         8:       return 36'sd4194282;
         9:       return 36'sd2097149;
         10:      return 36'sd1048575;
         11:      return 36'sd524287;
         12:      return 36'sd262143;
         13:      return 36'sd131071;
         14:      return 36'sd65535;
         15:      return 36'sd32767;
         16:      return 36'sd16383;
         17:      return 36'sd8191;
         18:      return 36'sd4095;
         19:      return 36'sd2047;
         20:      return 36'sd1023;
         21:      return 36'sd511;
         22:      return 36'sd255;
         23:      return 36'sd127;
         24:      return 36'sd63;
         25:      return 36'sd31;
         26:      return 36'sd15;
         27:      return 36'sd7;
         28:      return 36'sd3;
         29:      return 36'sd1;
         default: return '0;
      endcase
   endfunction

endpackage

### src/aarm_ifs.sv
// valid/ready channel interfaces for request and response words
// depends on aarm_pkg
interface aarm_req_if;
   logic              valid;
   logic              ready;
   aarm_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface aarm_rsp_if;
   logic              valid;
   logic              ready;
   aarm_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### src/axis_angle_rotation_matrix.sv
// Rotation matrix from angle and axis (Rodrigues form), fully pipelined.
// depends on aarm_pkg, aarm_ifs, aarm_cordic and aarm_norm
//
// req_chan carries one request word: angle in radians (Q3.12) and an axis of
// any scale. rsp_chan returns one word per request: the 3x3 rotation part of
// the column-major matrix in Q1.FRAC_BITS, plus bad_axis, which is set for
// an all-zero axis; the identity matrix is then given and the angle ignored.
// A word is taken when valid and ready are both high.
//
// From acceptance to rsp_chan.valid a word passes one stage of angle
// reduction and axis squaring, 32 square-root stages and 31 divider stages
// (the 30-stage cordic runs alongside), two product stages and a final
// sum, rounding and saturation stage that is the output register.
// Throughput is one word a cycle unless the receiver stalls.
// When the receiver stalls a finished word the whole pipeline holds and
// req_chan.ready drops; nothing is lost or repeated.
// Reset clears the valid bits of every stage; no words are in flight after.
module axis_angle_rotation_matrix #(
   parameter int FRAC_BITS = aarm_pkg::FRAC_BITS_DEF
) (
   input logic            clock,
   input logic            reset,
   aarm_req_if.sink       req_chan,
   aarm_rsp_if.source     rsp_chan
);
   import aarm_pkg::*;

   localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS;
   localparam int CS_DELAY   = NORM_LAT - CORDIC_STEPS;
   localparam int LAT        = NORM_LAT + 4;
   localparam int MW         = 37;
   localparam int SH         = 30 - FRAC_BITS;
   localparam logic signed [MW-1:0] HALF    = MW'((64'(1) << SH) >> 1);
   localparam logic signed [MW-1:0] ONE_OUT = MW'(64'(1) << FRAC_BITS);
   localparam logic signed [MW-1:0] SAT_HI  = MW'(32767);
   localparam logic signed [MW-1:0] SAT_LO  = -SAT_HI - MW'(1);
   localparam logic signed [15:0]   OUT_MAX =
      (ONE_OUT > SAT_HI) ? 16'sd32767 : 16'(ONE_OUT);

   function automatic logic signed [PW-1:0] qmul(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b);
      logic signed [2*PW-1:0] p;
      p = a * b;
      return p[PW+29:30];
   endfunction

   function automatic logic signed [15:0] to_out(input logic signed [MW-1:0] v);
      logic signed [MW-1:0] r;
      r = (v + HALF) >>> SH;
      if (r > ONE_OUT) r = ONE_OUT;
      if (r < -ONE_OUT) r = -ONE_OUT;
      if (r > SAT_HI) r = SAT_HI;
      if (r < SAT_LO) r = SAT_LO;
      return r[15:0];
   endfunction

   logic           en;
   logic [LAT-1:0] vld_ff, vld_in;

   assign en             = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign vld_in         = {vld_ff[LAT-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // stage a: angle reduction and squared axis length
   logic signed [CW-1:0] theta_w, theta_r, theta_f;
   logic                 neg_w, bad_w;
   logic signed [31:0]   sqx, sqy, sqz;
   logic [31:0]          n_w;

   always_comb begin
      theta_w = {{(CW-34){req_chan.data.angle[15]}}, req_chan.data.angle, 18'b0};
      // one wrap is enough for a Q3.12 angle
      if (theta_w > Q30_PI) begin
         theta_r = theta_w - Q30_TWO_PI;
      end else if (theta_w < -Q30_PI) begin
         theta_r = theta_w + Q30_TWO_PI;
      end else begin
         theta_r = theta_w;
      end
      neg_w = 1'b0;
      if (theta_r > Q30_HALF_PI) begin
         theta_f = theta_r - Q30_PI;
         neg_w   = 1'b1;
      end else if (theta_r < -Q30_HALF_PI) begin
         theta_f = theta_r + Q30_PI;
         neg_w   = 1'b1;
      end else begin
         theta_f = theta_r;
      end
      sqx   = 32'(req_chan.data.axis_x) * 32'(req_chan.data.axis_x);
      sqy   = 32'(req_chan.data.axis_y) * 32'(req_chan.data.axis_y);
      sqz   = 32'(req_chan.data.axis_z) * 32'(req_chan.data.axis_z);
      n_w   = 32'(sqx) + 32'(sqy) + 32'(sqz);
      bad_w = (req_chan.data.axis_x == 16'sd0) && (req_chan.data.axis_y == 16'sd0)
              && (req_chan.data.axis_z == 16'sd0);
   end

   logic signed [CW-1:0] a_theta_ff;
   logic                 a_neg_ff;
   logic [31:0]          a_n_ff;
   logic signed [15:0]   a_ax_ff, a_ay_ff, a_az_ff;
   logic                 bad_dl_ff [NORM_LAT+1];

   always_ff @(posedge clock) begin
      if (en) begin
         a_theta_ff   <= theta_f;
         a_neg_ff     <= neg_w;
         a_n_ff       <= n_w;
         a_ax_ff      <= req_chan.data.axis_x;
         a_ay_ff      <= req_chan.data.axis_y;
         a_az_ff      <= req_chan.data.axis_z;
         bad_dl_ff[0] <= bad_w;
         for (int i = 1; i <= NORM_LAT; i++) begin
            bad_dl_ff[i] <= bad_dl_ff[i-1];
         end
      end
   end

   logic signed [CW-1:0] cos_w, sin_w;
   logic signed [UW-1:0] ux_w, uy_w, uz_w;

   aarm_cordic u_cordic (
      .clock    (clock),
      .en       (en),
      .theta_in (a_theta_ff),
      .neg_in   (a_neg_ff),
      .cos_out  (cos_w),
      .sin_out  (sin_w)
   );

   aarm_norm u_norm (
      .clock  (clock),
      .en     (en),
      .n_in   (a_n_ff),
      .ax_in  (a_ax_ff),
      .ay_in  (a_ay_ff),
      .az_in  (a_az_ff),
      .ux_out (ux_w),
      .uy_out (uy_w),
      .uz_out (uz_w)
   );

   // line sine and cosine up with the unit axis
   logic signed [CW-1:0] c_dl_ff [CS_DELAY];
   logic signed [CW-1:0] s_dl_ff [CS_DELAY];

   always_ff @(posedge clock) begin
      if (en) begin
         c_dl_ff[0] <= cos_w;
         s_dl_ff[0] <= sin_w;
         for (int i = 1; i < CS_DELAY; i++) begin
            c_dl_ff[i] <= c_dl_ff[i-1];
            s_dl_ff[i] <= s_dl_ff[i-1];
         end
      end
   end

   // p1: axis outer products and 1 - cos
   logic signed [PW-1:0] p1_ux_ff, p1_uy_ff, p1_uz_ff, p1_c_ff, p1_s_ff, p1_t_ff;
   logic signed [PW-1:0] p1_xx_ff, p1_yy_ff, p1_zz_ff, p1_xy_ff, p1_xz_ff, p1_yz_ff;
   logic                 p1_bad_ff;
   logic signed [PW-1:0] ux_e, uy_e, uz_e;

   assign ux_e = PW'(ux_w);
   assign uy_e = PW'(uy_w);
   assign uz_e = PW'(uz_w);

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ux_ff  <= ux_e;
         p1_uy_ff  <= uy_e;
         p1_uz_ff  <= uz_e;
         p1_c_ff   <= PW'(c_dl_ff[CS_DELAY-1]);
         p1_s_ff   <= PW'(s_dl_ff[CS_DELAY-1]);
         p1_t_ff   <= PW'(Q30_ONE - c_dl_ff[CS_DELAY-1]);
         p1_xx_ff  <= qmul(ux_e, ux_e);
         p1_yy_ff  <= qmul(uy_e, uy_e);
         p1_zz_ff  <= qmul(uz_e, uz_e);
         p1_xy_ff  <= qmul(ux_e, uy_e);
         p1_xz_ff  <= qmul(ux_e, uz_e);
         p1_yz_ff  <= qmul(uy_e, uz_e);
         p1_bad_ff <= bad_dl_ff[NORM_LAT];
      end
   end

   // p2: scaled terms
   logic signed [PW-1:0] p2_txx_ff, p2_tyy_ff, p2_tzz_ff, p2_txy_ff, p2_txz_ff, p2_tyz_ff;
   logic signed [PW-1:0] p2_xs_ff, p2_ys_ff, p2_zs_ff, p2_c_ff;
   logic                 p2_bad_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p2_txx_ff <= qmul(p1_t_ff, p1_xx_ff);
         p2_tyy_ff <= qmul(p1_t_ff, p1_yy_ff);
         p2_tzz_ff <= qmul(p1_t_ff, p1_zz_ff);
         p2_txy_ff <= qmul(p1_t_ff, p1_xy_ff);
         p2_txz_ff <= qmul(p1_t_ff, p1_xz_ff);
         p2_tyz_ff <= qmul(p1_t_ff, p1_yz_ff);
         p2_xs_ff  <= qmul(p1_ux_ff, p1_s_ff);
         p2_ys_ff  <= qmul(p1_uy_ff, p1_s_ff);
         p2_zs_ff  <= qmul(p1_uz_ff, p1_s_ff);
         p2_c_ff   <= p1_c_ff;
         p2_bad_ff <= p1_bad_ff;
      end
   end

   // p3: sums, identity for a zero axis, rounding into the output register
   logic signed [MW-1:0] m [9];
   rsp_type              rsp_in, rsp_ff;

   always_comb begin
      if (p2_bad_ff) begin
         for (int i = 0; i < 9; i++) begin
            m[i] = (i % 4 == 0) ? MW'(Q30_ONE) : '0;
         end
      end else begin
         m[0] = MW'(p2_c_ff) + MW'(p2_txx_ff);
         m[1] = MW'(p2_txy_ff) + MW'(p2_zs_ff);
         m[2] = MW'(p2_txz_ff) - MW'(p2_ys_ff);
         m[3] = MW'(p2_txy_ff) - MW'(p2_zs_ff);
         m[4] = MW'(p2_c_ff) + MW'(p2_tyy_ff);
         m[5] = MW'(p2_tyz_ff) + MW'(p2_xs_ff);
         m[6] = MW'(p2_txz_ff) + MW'(p2_ys_ff);
         m[7] = MW'(p2_tyz_ff) - MW'(p2_xs_ff);
         m[8] = MW'(p2_c_ff) + MW'(p2_tzz_ff);
      end
      rsp_in.col0_x   = to_out(m[0]);
      rsp_in.col0_y   = to_out(m[1]);
      rsp_in.col0_z   = to_out(m[2]);
      rsp_in.col1_x   = to_out(m[3]);
      rsp_in.col1_y   = to_out(m[4]);
      rsp_in.col1_z   = to_out(m[5]);
      rsp_in.col2_x   = to_out(m[6]);
      rsp_in.col2_y   = to_out(m[7]);
      rsp_in.col2_z   = to_out(m[8]);
      rsp_in.bad_axis = p2_bad_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = vld_ff[LAT-1];
   assign rsp_chan.data  = rsp_ff;

`ifndef ASSERT_OFF
   a_bad_identity : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.bad_axis |->
         rsp_chan.data.col0_y == 16'sd0 && rsp_chan.data.col0_z == 16'sd0 &&
         rsp_chan.data.col1_x == 16'sd0 && rsp_chan.data.col1_z == 16'sd0 &&
         rsp_chan.data.col2_x == 16'sd0 && rsp_chan.data.col2_y == 16'sd0 &&
         rsp_chan.data.col0_x == OUT_MAX)
      else $error("zero axis word is not the identity");

   a_diag_range : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         rsp_chan.data.col0_x <= OUT_MAX && rsp_chan.data.col0_x >= -OUT_MAX &&
         rsp_chan.data.col1_y <= OUT_MAX && rsp_chan.data.col1_y >= -OUT_MAX &&
         rsp_chan.data.col2_z <= OUT_MAX && rsp_chan.data.col2_z >= -OUT_MAX)
      else $error("diagonal element outside unit range");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");
`endif

endmodule

### src/aarm_cordic.sv
// pipelined rotation-mode cordic, one micro-rotation per register stage
// depends on aarm_pkg
module aarm_cordic (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [aarm_pkg::CW-1:0] theta_in,
   input  logic                          neg_in,
   output logic signed [aarm_pkg::CW-1:0] cos_out,
   output logic signed [aarm_pkg::CW-1:0] sin_out
);
   import aarm_pkg::*;

   localparam int L = CORDIC_STEPS - 1;

   logic signed [CW-1:0] x_ff [CORDIC_STEPS];
   logic signed [CW-1:0] y_ff [CORDIC_STEPS];
   logic signed [CW-1:0] z_ff [CORDIC_STEPS-1];
   logic                 neg_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CW-1:0] xp, yp, zp;
      logic                 np;

      if (i == 0) begin : g_first
         assign xp = CORDIC_X0;
         assign yp = '0;
         assign zp = theta_in;
         assign np = neg_in;
      end else begin : g_next
         assign xp = x_ff[i-1];
         assign yp = y_ff[i-1];
         assign zp = z_ff[i-1];
         assign np = neg_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i] <= np;
            if (zp >= 0) begin
               x_ff[i] <= xp - (yp >>> i);
               y_ff[i] <= yp + (xp >>> i);
            end else begin
               x_ff[i] <= xp + (yp >>> i);
               y_ff[i] <= yp - (xp >>> i);
            end
         end
      end

      // residual angle is not needed after the last step
      if (i < CORDIC_STEPS - 1) begin : g_z
         always_ff @(posedge clock) begin
            if (en) begin
               z_ff[i] <= (zp >= 0) ? zp - atan_q30(i) : zp + atan_q30(i);
            end
         end
      end
   end

   // undo the half-turn fold
   assign cos_out = neg_ff[L] ? -x_ff[L] : x_ff[L];
   assign sin_out = neg_ff[L] ? -y_ff[L] : y_ff[L];

endmodule

### src/aarm_norm.sv
// axis normalisation: pipelined integer square root, two bits a stage,
// then three restoring dividers, one quotient bit a stage; depends on aarm_pkg
module aarm_norm (
   input  logic                          clock,
   input  logic                          en,
   input  logic [31:0]                   n_in,
   input  logic signed [15:0]            ax_in,
   input  logic signed [15:0]            ay_in,
   input  logic signed [15:0]            az_in,
   output logic signed [aarm_pkg::UW-1:0] ux_out,
   output logic signed [aarm_pkg::UW-1:0] uy_out,
   output logic signed [aarm_pkg::UW-1:0] uz_out
);
   import aarm_pkg::*;

   localparam int SQ = SQRT_STEPS;
   localparam int DV = DIV_STEPS;

   // square root pipeline
   logic [35:0]      srem_ff  [SQ-1];
   logic [31:0]      sroot_ff [SQ];
   logic [31:0]      sn_ff    [15];
   logic [2:0][15:0] smag_ff  [SQ];
   logic [2:0]       ssg_ff   [SQ];

   // divider pipeline
   logic [2:0][33:0] drem_ff [DV-1];
   logic [2:0][30:0] dq_ff   [DV-1];
   logic [31:0]      dr_ff   [DV-1];
   logic [2:0]       dsg_ff  [DV-1];
   logic signed [UW-1:0] u_ff [3];

   logic [2:0][15:0] mag_in;
   logic [2:0]       sg_in;

   always_comb begin
      sg_in     = {az_in[15], ay_in[15], ax_in[15]};
      mag_in[0] = ax_in[15] ? 16'(-ax_in) : 16'(ax_in);
      mag_in[1] = ay_in[15] ? 16'(-ay_in) : 16'(ay_in);
      mag_in[2] = az_in[15] ? 16'(-az_in) : 16'(az_in);
   end

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      logic [35:0]      prem, cand, trial;
      logic [31:0]      proot;
      logic [1:0]       bits;
      logic [2:0][15:0] pmag;
      logic [2:0]       psg;
      logic             ge;

      if (k == 0) begin : g_first
         assign prem  = '0;
         assign proot = '0;
         assign bits  = n_in[31:30];
         assign pmag  = mag_in;
         assign psg   = sg_in;
      end else begin : g_next
         assign prem  = srem_ff[k-1];
         assign proot = sroot_ff[k-1];
         assign pmag  = smag_ff[k-1];
         assign psg   = ssg_ff[k-1];
         // low half of the radicand is all zero
         if (k < 16) begin : g_bits
            assign bits = sn_ff[k-1][31-2*k -: 2];
         end else begin : g_zero
            assign bits = 2'b00;
         end
      end

      assign cand  = {prem[33:0], bits};
      assign trial = {2'b00, proot, 2'b01};
      assign ge    = (cand >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            sroot_ff[k] <= {proot[30:0], ge};
            smag_ff[k]  <= pmag;
            ssg_ff[k]   <= psg;
         end
      end

      if (k < SQ - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               srem_ff[k] <= ge ? cand - trial : cand;
            end
         end
      end

      if (k < 15) begin : g_n
         logic [31:0] pn;
         if (k == 0) begin : g_n0
            assign pn = n_in;
         end else begin : g_nk
            assign pn = sn_ff[k-1];
         end
         always_ff @(posedge clock) begin
            if (en) begin
               sn_ff[k] <= pn;
            end
         end
      end
   end

   for (genvar j = 0; j < DV; j++) begin : g_div
      logic [2:0][33:0] prem, nrem;
      logic [2:0][30:0] pq, nq;
      logic [31:0]      pr;
      logic [2:0]       psg;

      if (j == 0) begin : g_first
         for (genvar c = 0; c < 3; c++) begin : g_c
            assign prem[c] = {3'b000, smag_ff[SQ-1][c], 15'b0};
         end
         assign pq  = '0;
         assign pr  = sroot_ff[SQ-1];
         assign psg = ssg_ff[SQ-1];
      end else begin : g_next
         assign prem = drem_ff[j-1];
         assign pq   = dq_ff[j-1];
         assign pr   = dr_ff[j-1];
         assign psg  = dsg_ff[j-1];
      end

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            logic [33:0] sh;
            logic        ge;
            sh      = {prem[c][32:0], 1'b0};
            ge      = (sh >= {2'b00, pr});
            nrem[c] = ge ? sh - {2'b00, pr} : sh;
            nq[c]   = {pq[c][29:0], ge};
         end
      end

      if (j < DV - 1) begin : g_mid
         always_ff @(posedge clock) begin
            if (en) begin
               drem_ff[j] <= nrem;
               dq_ff[j]   <= nq;
               dr_ff[j]   <= pr;
               dsg_ff[j]  <= psg;
            end
         end
      end else begin : g_last
         // last remainder is dropped, sign goes back on
         always_ff @(posedge clock) begin
            if (en) begin
               for (int c = 0; c < 3; c++) begin
                  u_ff[c] <= psg[c] ? -$signed({1'b0, nq[c]}) : $signed({1'b0, nq[c]});
               end
            end
         end
      end
   end

   assign ux_out = u_ff[0];
   assign uy_out = u_ff[1];
   assign uz_out = u_ff[2];

endmodule

### bench/axis_angle_rotation_matrix_tb.sv
// self-checking bench for the axis-angle rotation matrix block
// depends on aarm_pkg, aarm_ifs and the block itself; predicts each matrix word in place
module axis_angle_rotation_matrix_tb;
   import aarm_pkg::*;

   localparam int FB = FRAC_BITS_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aarm_req_if req_chan ();
   aarm_rsp_if rsp_chan ();

   axis_angle_rotation_matrix #(.FRAC_BITS(FB)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   typedef struct {
      req_type word;
      logic    known;
      rsp_type matrix;
   } vector_row;

   rsp_type matrix_queue[$];
   int      mismatches = 0;
   bit      sending_done = 1'b0;
   bit      long_hold = 1'b0;

   const longint ATAN[30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1};

   function automatic logic signed [15:0] round_q(longint v);
      longint one;
      one = longint'(1) << FB;
      if (FB < 30) v = (v + (longint'(1) << (29 - FB))) >>> (30 - FB);
      if (v > one) v = one;
      if (v < -one) v = -one;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic longint qm(longint a, longint b);
      return (a * b) >>> 30;
   endfunction

   function automatic rsp_type rotation_of(req_type w);
      rsp_type o;
      longint ax, ay, az, th, x, y, z, dx, dy, c, s, t;
      longint ux, uy, uz, xx, yy, zz, xy, xz, yz;
      longint m[9];
      longint unsigned n, r, rem, bitv, mag;
      bit neg;
      ax = w.axis_x; ay = w.axis_y; az = w.axis_z;
      if (ax == 0 && ay == 0 && az == 0) begin
         for (int i = 0; i < 9; i++) m[i] = (i % 4 == 0) ? 64'sd1073741824 : 0;
      end else begin
         th = longint'(w.angle) * 262144;
         neg = 1'b0;
         while (th > 64'sd3373259426) th -= 64'sd6746518852;
         while (th < -64'sd3373259426) th += 64'sd6746518852;
         if (th > 64'sd1686629713) begin th -= 64'sd3373259426; neg = 1'b1; end
         else if (th < -64'sd1686629713) begin th += 64'sd3373259426; neg = 1'b1; end
         x = 652032874; y = 0; z = th;
         for (int i = 0; i < 30; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= ATAN[i]; end
            else begin x += dx; y -= dy; z += ATAN[i]; end
         end
         c = neg ? -x : x;
         s = neg ? -y : y;
         t = 1073741824 - c;
         n = ax * ax + ay * ay + az * az;
         rem = n << 32; r = 0; bitv = 64'd1 << 62;
         while (bitv > rem) bitv >>= 2;
         while (bitv != 0) begin
            if (rem >= r + bitv) begin rem -= r + bitv; r = (r >> 1) + bitv; end
            else r >>= 1;
            bitv >>= 2;
         end
         mag = (ax < 0) ? -ax : ax; ux = (mag << 46) / r; if (ax < 0) ux = -ux;
         mag = (ay < 0) ? -ay : ay; uy = (mag << 46) / r; if (ay < 0) uy = -uy;
         mag = (az < 0) ? -az : az; uz = (mag << 46) / r; if (az < 0) uz = -uz;
         xx = qm(ux, ux); yy = qm(uy, uy); zz = qm(uz, uz);
         xy = qm(ux, uy); xz = qm(ux, uz); yz = qm(uy, uz);
         m[0] = c + qm(t, xx);
         m[1] = qm(t, xy) + qm(uz, s);
         m[2] = qm(t, xz) - qm(uy, s);
         m[3] = qm(t, xy) - qm(uz, s);
         m[4] = c + qm(t, yy);
         m[5] = qm(t, yz) + qm(ux, s);
         m[6] = qm(t, xz) + qm(uy, s);
         m[7] = qm(t, yz) - qm(ux, s);
         m[8] = c + qm(t, zz);
      end
      o.col0_x = round_q(m[0]); o.col0_y = round_q(m[1]); o.col0_z = round_q(m[2]);
      o.col1_x = round_q(m[3]); o.col1_y = round_q(m[4]); o.col1_z = round_q(m[5]);
      o.col2_x = round_q(m[6]); o.col2_y = round_q(m[7]); o.col2_z = round_q(m[8]);
      o.bad_axis = (ax == 0 && ay == 0 && az == 0);
      return o;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   function automatic req_type random_word();
      req_type w;
      w.angle  = 16'($urandom);
      w.axis_x = 16'($urandom); w.axis_y = 16'($urandom); w.axis_z = 16'($urandom);
      case ($urandom_range(0, 9))
         0: begin w.axis_x = 0; w.axis_y = 0; w.axis_z = 0; end
         1: begin w.axis_y = 0; w.axis_z = 0; end
         2: begin
            w.axis_x = $signed(5'($urandom)); w.axis_y = $signed(5'($urandom));
            w.axis_z = $signed(5'($urandom));
         end
         default: ;
      endcase
      return w;
   endfunction

   // identity word for an all-zero axis
   function automatic rsp_type identity_word();
      rsp_type o;
      o = '0;
      o.col0_x = 16'sd1 <<< FB; o.col1_y = 16'sd1 <<< FB; o.col2_z = 16'sd1 <<< FB;
      o.bad_axis = 1'b1;
      return o;
   endfunction

   vector_row vectors[$];

   task automatic send_word(req_type w);
      req_chan.valid <= 1'b1;
      req_chan.data  <= w;
      do @(posedge clock); while (!req_chan.ready);
      matrix_queue.push_back(rotation_of(w));
   endtask

   initial begin
      vector_row row;
      req_type w;
      int g;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      row.known = 1'b1; row.matrix = identity_word();
      row.word = '{16'sd0, 16'sd0, 16'sd0, 16'sd0}; vectors.push_back(row);
      row.word = '{16'sh7fff, 16'sd0, 16'sd0, 16'sd0}; vectors.push_back(row);
      row.word = '{-16'sd32768, 16'sd0, 16'sd0, 16'sd0}; vectors.push_back(row);
      row.known = 1'b0;
      row.word = '{16'sd0, 16'sd1, 16'sd0, 16'sd0}; vectors.push_back(row);
      row.word = '{16'sd6434, 16'sd0, 16'sd0, 16'sd1}; vectors.push_back(row);
      row.word = '{-16'sd6434, 16'sd0, 16'sd1, 16'sd0}; vectors.push_back(row);
      row.word = '{16'sd12868, 16'sd1, 16'sd1, 16'sd1}; vectors.push_back(row);
      row.word = '{16'sd32767, 16'sh7fff, 16'sh7fff, 16'sh7fff}; vectors.push_back(row);
      row.word = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
      vectors.push_back(row);
      row.word = '{16'sd3217, -16'sd32768, 16'sh7fff, -16'sd1}; vectors.push_back(row);
      row.word = '{16'sd25736, -16'sd1, 16'sd0, 16'sd0}; vectors.push_back(row);
      row.word = '{-16'sd12868, 16'sd0, 16'sd0, -16'sd32768}; vectors.push_back(row);
      row.word = '{16'sd1, 16'sd3, -16'sd4, 16'sd12}; vectors.push_back(row);

      foreach (vectors[i]) begin
         send_word(vectors[i].word);
         // directed rows with a typed-in answer are checked against it instead
         if (vectors[i].known) matrix_queue[$] = vectors[i].matrix;
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end

      for (int k = 0; k < 600; k++) begin
         w = random_word();
         send_word(w);
         g = long_hold ? 0 : gap_len();
         if (g > 0) begin
            req_chan.valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;
      sending_done = 1'b1;
   end

   // receiver: random stalls plus one long hold-off while the sender keeps offering
   initial begin
      int g;
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      repeat (200) @(posedge clock);
      long_hold = 1'b1;
      rsp_chan.ready <= 1'b0;
      repeat (300) @(posedge clock);
      long_hold = 1'b0;
      forever begin
         rsp_chan.ready <= 1'b1;
         if ($urandom_range(0, 2) == 0) begin
            @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
         g = gap_len();
         if (g > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (matrix_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_chan.data);
         end else begin
            want = matrix_queue.pop_front();
            if (rsp_chan.data !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word mismatch: expected %h actual %h", want, rsp_chan.data);
            end
         end
      end
   end

   initial begin
      wait (sending_done);
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("axis_angle_rotation_matrix: match");
      end else begin
         $display("axis_angle_rotation_matrix: mismatch");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("axis_angle_rotation_matrix: mismatch");
      $finish;
   end

endmodule

### axis_angle_rotation_matrix.f
src/aarm_pkg.sv
src/aarm_ifs.sv
src/aarm_cordic.sv
src/aarm_norm.sv
src/axis_angle_rotation_matrix.sv
bench/axis_angle_rotation_matrix_tb.sv
